### src/cstp_pkg.sv
// types and constants of the call stack time profiler
// used by the interfaces, the table ram users and the top level
package cstp_pkg;

  localparam int unsigned FuncW  = 10;
  localparam int unsigned DeltaW = 32;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned DepthW = 9;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned CallsW = 32;

  localparam logic [DepthW-1:0] DepthMax = '1;

  typedef enum logic [1:0] {
    EV_ENTRY      = 2'd0,
    EV_EXIT       = 2'd1,
    EV_PROF_START = 2'd2,
    EV_RESERVED   = 2'd3
  } event_e;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_BAD_EVENT = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TOPADDR,
    S_TOPDATA,
    S_FDATA,
    S_FMOD,
    S_OUT
  } state_e;

  // one function's table entry
  typedef struct packed {
    logic [CallsW-1:0] calls;
    logic [DepthW-1:0] depth;
    logic              child;
    logic [TimeW-1:0]  start;
    logic [TimeW-1:0]  incl;
    logic [TimeW-1:0]  excl;
  } fent_t;

  localparam int unsigned FentW = $bits(fent_t);

endpackage

### src/cstp_if.sv
// item channels of the call stack time profiler
// depends on cstp_pkg
interface cstp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [1:0]                    event_kind;
  logic [cstp_pkg::FuncW-1:0]    func_index;
  logic [cstp_pkg::DeltaW-1:0]   delta_ticks;

  modport source (output valid, op, event_kind, func_index, delta_ticks, input ready);
  modport sink (input valid, op, event_kind, func_index, delta_ticks, output ready);
endinterface

interface cstp_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [cstp_pkg::CallsW-1:0]   call_count;
  logic [cstp_pkg::TimeW-1:0]    inclusive_time;
  logic [cstp_pkg::TimeW-1:0]    exclusive_time;
  logic [cstp_pkg::DepthW-1:0]   recursion_depth;
  logic [cstp_pkg::DepthW-1:0]   path_depth;

  modport source (output valid, status, call_count, inclusive_time, exclusive_time,
                  recursion_depth, path_depth, input ready);
  modport sink (input valid, status, call_count, inclusive_time, exclusive_time,
                recursion_depth, path_depth, output ready);
endinterface

### src/cstp_ram.sv
// generic simple dual port ram, one write and one registered read port
// read during write to the same address returns the old data
module cstp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/call_stack_time_profiler_core.sv
// call stack time profiler: trace events update a per-function table and a call stack
// depends on cstp_pkg, cstp_if and cstp_ram
// record item: stack top address, top entry update, entry read, entry update and result states;
//   an entry on an empty stack skips the first two, and a read item has entry read and result
//   only; one item at a time through the table ram port, no new item before the result is out
// reset: a clearing pass zeroes the table; no item accepted meanwhile
module call_stack_time_profiler_core #(
  parameter int unsigned NumFunctions = 1024,
  parameter int unsigned StackDepth   = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cstp_pkg::CfgW-1:0] cfg_wdata_i,
  cstp_in_if.sink                   in_i,
  cstp_out_if.source                out_o
);

  localparam int unsigned FAw   = $clog2(NumFunctions);
  localparam int unsigned StkAw = $clog2(StackDepth);
  localparam int unsigned SpW   = $clog2(StackDepth + 1);
  localparam int unsigned ExtW  = 17;

  cstp_pkg::state_e              state_q, state_d;
  logic [cstp_pkg::CfgW-1:0]     fcount_q, fcount_d;
  logic [cstp_pkg::TimeW-1:0]    run_q, run_d;
  logic [1:0]                    last_q, last_d;
  logic                          prev_exit_q, prev_exit_d;
  logic [SpW-1:0]                sp_q, sp_d;
  logic [FAw-1:0]                clr_q, clr_d;
  logic                          op_q, op_d;
  logic                          entry_q, entry_d;
  logic [cstp_pkg::FuncW-1:0]    f_q, f_d;
  logic [cstp_pkg::DeltaW-1:0]   delta_q, delta_d;
  logic [cstp_pkg::FuncW-1:0]    top_q, top_d;
  logic                          topv_q, topv_d;
  cstp_pkg::fent_t               fwd_q, fwd_d;
  cstp_pkg::fent_t               ent_q, ent_d;
  logic [cstp_pkg::TimeW-1:0]    elap_q, elap_d;

  logic                          out_valid_q, out_valid_d;
  logic [2:0]                    out_status_q, out_status_d;
  cstp_pkg::fent_t               out_ent_q, out_ent_d;
  logic [cstp_pkg::DepthW-1:0]   out_path_q, out_path_d;

  logic                          tab_we;
  logic [FAw-1:0]                tab_waddr, tab_raddr;
  cstp_pkg::fent_t               tab_wdata, tab_rdata;
  logic                          stk_we;
  logic [StkAw-1:0]              stk_waddr, stk_raddr;
  logic [cstp_pkg::FuncW-1:0]    stk_wdata, stk_rdata;

  logic                          accept, out_free, unknown;
  logic [ExtW-1:0]               f_ext, top_ext, in_ext;
  logic [SpW-1:0]                sp_dec;
  cstp_pkg::fent_t               t, e;

  cstp_ram #(.Width(cstp_pkg::FentW), .Depth(NumFunctions)) u_tab (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  cstp_ram #(.Width(cstp_pkg::FuncW), .Depth(StackDepth)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == cstp_pkg::S_IDLE) && out_free;
  assign accept    = in_i.valid && in_i.ready;
  assign in_ext    = ExtW'(in_i.func_index);
  assign f_ext     = ExtW'(f_q);
  assign top_ext   = ExtW'(stk_rdata);
  assign sp_dec    = sp_q - SpW'(1);
  assign unknown   = (32'(in_i.func_index) >= 32'(fcount_q)) ||
                     (32'(in_i.func_index) >= 32'(NumFunctions));

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.call_count      = out_ent_q.calls;
  assign out_o.inclusive_time  = out_ent_q.incl;
  assign out_o.exclusive_time  = out_ent_q.excl;
  assign out_o.recursion_depth = out_ent_q.depth;
  assign out_o.path_depth      = out_path_q;

  always_comb begin
    state_d      = state_q;
    fcount_d     = cfg_we_i ? cfg_wdata_i : fcount_q;
    run_d        = run_q;
    last_d       = last_q;
    prev_exit_d  = prev_exit_q;
    sp_d         = sp_q;
    clr_d        = clr_q;
    op_d         = op_q;
    entry_d      = entry_q;
    f_d          = f_q;
    delta_d      = delta_q;
    top_d        = top_q;
    topv_d       = topv_q;
    fwd_d        = fwd_q;
    ent_d        = ent_q;
    elap_d       = elap_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_path_d   = out_path_q;
    tab_we       = 1'b0;
    tab_waddr    = f_ext[FAw-1:0];
    tab_wdata    = '0;
    tab_raddr    = f_ext[FAw-1:0];
    stk_we       = 1'b0;
    stk_waddr    = sp_q[StkAw-1:0];
    stk_wdata    = f_q;
    stk_raddr    = sp_dec[StkAw-1:0];
    t            = tab_rdata;
    e            = ent_q;

    case (state_q)
      cstp_pkg::S_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_q;
        clr_d     = clr_q + FAw'(1);
        if (clr_q == FAw'(NumFunctions - 1)) begin
          state_d = cstp_pkg::S_IDLE;
        end
      end
      cstp_pkg::S_IDLE: begin
        if (accept) begin
          op_d      = in_i.op;
          entry_d   = (in_i.event_kind == cstp_pkg::EV_ENTRY);
          f_d       = in_i.func_index;
          delta_d   = in_i.delta_ticks;
          topv_d    = 1'b0;
          tab_raddr = in_ext[FAw-1:0];
          out_ent_d  = '0;
          out_path_d = cstp_pkg::DepthW'(sp_q);
          if (unknown) begin
            out_valid_d  = 1'b1;
            out_status_d = cstp_pkg::ST_UNKNOWN;
          end else if (in_i.op == cstp_pkg::OP_READ) begin
            state_d = cstp_pkg::S_FDATA;
          end else if (in_i.event_kind != cstp_pkg::EV_ENTRY &&
                       in_i.event_kind != cstp_pkg::EV_EXIT) begin
            out_valid_d  = 1'b1;
            out_status_d = cstp_pkg::ST_BAD_EVENT;
          end else if (in_i.event_kind == cstp_pkg::EV_ENTRY &&
                       sp_q == SpW'(StackDepth)) begin
            out_valid_d  = 1'b1;
            out_status_d = cstp_pkg::ST_FULL;
          end else if (in_i.event_kind == cstp_pkg::EV_EXIT && sp_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = cstp_pkg::ST_EMPTY;
          end else begin
            run_d       = run_q + cstp_pkg::TimeW'(in_i.delta_ticks);
            prev_exit_d = (last_q == cstp_pkg::EV_EXIT);
            last_d      = in_i.event_kind;
            if (sp_q == '0) begin
              state_d = cstp_pkg::S_FDATA;
            end else begin
              state_d = cstp_pkg::S_TOPADDR;
            end
          end
        end
      end
      cstp_pkg::S_TOPADDR: begin
        // stack top arrives, fetch its table entry
        top_d     = stk_rdata;
        topv_d    = 1'b1;
        tab_raddr = top_ext[FAw-1:0];
        state_d   = cstp_pkg::S_TOPDATA;
      end
      cstp_pkg::S_TOPDATA: begin
        t = tab_rdata;
        if (entry_q) begin
          t.excl  = t.excl + cstp_pkg::TimeW'(delta_q);
          t.child = 1'b1;
        end else if (prev_exit_q) begin
          t.excl  = t.excl + cstp_pkg::TimeW'(delta_q);
        end
        tab_we    = 1'b1;
        tab_waddr = ExtW'(top_q) == f_ext ? f_ext[FAw-1:0] : FAw'(ExtW'(top_q));
        tab_wdata = t;
        fwd_d     = t;
        state_d   = cstp_pkg::S_FDATA;
      end
      cstp_pkg::S_FDATA: begin
        // the top entry was just written back; forward it when it is the same function
        e = (topv_q && top_q == f_q) ? fwd_q : tab_rdata;
        ent_d  = e;
        elap_d = run_q - e.start;
        if (op_q == cstp_pkg::OP_READ) begin
          state_d = cstp_pkg::S_OUT;
        end else begin
          state_d = cstp_pkg::S_FMOD;
        end
      end
      cstp_pkg::S_FMOD: begin
        e = ent_q;
        if (entry_q) begin
          if (e.calls != '1) begin
            e.calls = e.calls + cstp_pkg::CallsW'(1);
          end
          e.child = 1'b0;
          if (e.depth == '0) begin
            e.start = run_q;
          end
          if (e.depth != cstp_pkg::DepthMax) begin
            e.depth = e.depth + cstp_pkg::DepthW'(1);
          end
          stk_we = 1'b1;
          sp_d   = sp_q + SpW'(1);
        end else begin
          if (e.depth != '0) begin
            if (e.depth == cstp_pkg::DepthW'(1)) begin
              e.incl = e.incl + elap_q;
            end
            e.depth = e.depth - cstp_pkg::DepthW'(1);
          end
          if (!e.child) begin
            e.excl = e.excl + cstp_pkg::TimeW'(delta_q);
          end
          sp_d = sp_dec;
        end
        tab_we    = 1'b1;
        tab_wdata = e;
        ent_d     = e;
        state_d   = cstp_pkg::S_OUT;
      end
      cstp_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = cstp_pkg::ST_OK;
          out_ent_d    = ent_q;
          out_path_d   = cstp_pkg::DepthW'(sp_q);
          state_d      = cstp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cstp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cstp_pkg::S_CLEAR;
      fcount_q    <= cstp_pkg::CfgW'(1024);
      run_q       <= '0;
      last_q      <= cstp_pkg::EV_PROF_START;
      prev_exit_q <= 1'b0;
      sp_q        <= '0;
      clr_q       <= '0;
      topv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fcount_q    <= fcount_d;
      run_q       <= run_d;
      last_q      <= last_d;
      prev_exit_q <= prev_exit_d;
      sp_q        <= sp_d;
      clr_q       <= clr_d;
      topv_q      <= topv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    entry_q      <= entry_d;
    f_q          <= f_d;
    delta_q      <= delta_d;
    top_q        <= top_d;
    fwd_q        <= fwd_d;
    ent_q        <= ent_d;
    elap_q       <= elap_d;
    out_status_q <= out_status_d;
    out_ent_q    <= out_ent_d;
    out_path_q   <= out_path_d;
  end

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cstp_pkg::S_CLEAR) |-> !in_i.ready)
    else $error("item accepted during table clear");

  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth))
    else $error("stack pointer beyond stack depth");

  a_reject_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && unknown) |=> (out_valid_q && out_status_q == cstp_pkg::ST_UNKNOWN))
    else $error("unknown function item gave no result");

  a_sp_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cstp_pkg::S_FMOD) |=> (sp_q == $past(sp_q)))
    else $error("stack pointer moved outside the update cycle");

endmodule

### tb/call_stack_time_profiler_core_tb.sv
// testbench of call_stack_time_profiler_core: directed and random trace events and reads
// depends on cstp_pkg, cstp_if and the core; results checked against an in-bench profile table
`timescale 1ns / 1ps

module call_stack_time_profiler_core_tb;

  localparam int unsigned NFunc = 1024;
  localparam int unsigned NStack = 256;

  typedef struct {
    logic [2:0]                  status;
    logic [cstp_pkg::CallsW-1:0] calls;
    logic [cstp_pkg::TimeW-1:0]  incl;
    logic [cstp_pkg::TimeW-1:0]  excl;
    logic [cstp_pkg::DepthW-1:0] depth;
    logic [cstp_pkg::DepthW-1:0] path;
  } counters_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [cstp_pkg::CfgW-1:0] cfg_wdata_i;

  cstp_in_if  in_if ();
  cstp_out_if out_if ();

  call_stack_time_profiler_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // profile state mirrored in the bench
  logic [cstp_pkg::CfgW-1:0]   known_funcs;
  logic [cstp_pkg::TimeW-1:0]  now_ticks;
  cstp_pkg::event_e            prev_kind;
  logic [cstp_pkg::FuncW-1:0]  frames [NStack];
  int unsigned                 sp;
  logic [cstp_pkg::CallsW-1:0] calls_of [NFunc];
  logic [cstp_pkg::DepthW-1:0] depth_of [NFunc];
  logic                        has_child [NFunc];
  logic [cstp_pkg::TimeW-1:0]  started_at [NFunc];
  logic [cstp_pkg::TimeW-1:0]  incl_of [NFunc];
  logic [cstp_pkg::TimeW-1:0]  excl_of [NFunc];

  counters_t pending_counters [$];
  int        errors;
  int        hold_len;
  bit        rx_eager;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("call_stack_time_profiler_core_tb: errors");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic counters_t profile_step(logic op, logic [1:0] kind,
                                             logic [cstp_pkg::FuncW-1:0] f,
                                             logic [cstp_pkg::DeltaW-1:0] d);
    counters_t c;
    logic [cstp_pkg::FuncW-1:0] top;
    c = '{status: cstp_pkg::ST_OK, calls: '0, incl: '0, excl: '0, depth: '0, path: '0};
    if (f >= known_funcs) begin
      c.status = cstp_pkg::ST_UNKNOWN;
    end else if (op == cstp_pkg::OP_RECORD) begin
      if (kind == cstp_pkg::EV_ENTRY) begin
        if (sp >= NStack) begin
          c.status = cstp_pkg::ST_FULL;
        end else begin
          now_ticks += d;
          if (sp > 0) begin
            top = frames[sp-1];
            excl_of[top] += d;
            has_child[top] = 1'b1;
          end
          if (calls_of[f] != '1) calls_of[f]++;
          frames[sp] = f;
          sp++;
          has_child[f] = 1'b0;
          if (depth_of[f] == 0) started_at[f] = now_ticks;
          if (depth_of[f] != cstp_pkg::DepthMax) depth_of[f]++;
          prev_kind = cstp_pkg::EV_ENTRY;
        end
      end else if (kind == cstp_pkg::EV_EXIT) begin
        if (sp == 0) begin
          c.status = cstp_pkg::ST_EMPTY;
        end else begin
          now_ticks += d;
          top = frames[sp-1];
          if (prev_kind == cstp_pkg::EV_EXIT) excl_of[top] += d;
          if (depth_of[f] != 0) begin
            depth_of[f]--;
            if (depth_of[f] == 0) incl_of[f] += now_ticks - started_at[f];
          end
          sp--;
          if (!has_child[f]) excl_of[f] += d;
          prev_kind = cstp_pkg::EV_EXIT;
        end
      end else begin
        c.status = cstp_pkg::ST_BAD_EVENT;
      end
    end
    if (c.status == cstp_pkg::ST_OK) begin
      c.calls = calls_of[f];
      c.incl  = incl_of[f];
      c.excl  = excl_of[f];
      c.depth = depth_of[f];
    end
    c.path = sp[cstp_pkg::DepthW-1:0];
    return c;
  endfunction

  task automatic send_item(logic op, logic [1:0] kind, logic [cstp_pkg::FuncW-1:0] f,
                           logic [cstp_pkg::DeltaW-1:0] d);
    int g;
    counters_t c;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.event_kind  <= kind;
    in_if.func_index  <= f;
    in_if.delta_ticks <= d;
    do @(posedge clk_i); while (!in_if.ready);
    c = profile_step(op, kind, f, d);
    pending_counters = {pending_counters, c};
  endtask

  // pause the sender until every result is back, plus the block latency
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_counters.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_function_count(logic [cstp_pkg::CfgW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    known_funcs = (v > NFunc) ? cstp_pkg::CfgW'(NFunc) : v;
  endtask

  function automatic logic [cstp_pkg::DeltaW-1:0] rand_delta();
    return ($urandom_range(99) < 70) ? cstp_pkg::DeltaW'($urandom_range(1000)) :
                                       cstp_pkg::DeltaW'($urandom);
  endfunction

  function automatic logic [cstp_pkg::FuncW-1:0] rand_func();
    return ($urandom_range(99) < 70) ? cstp_pkg::FuncW'($urandom_range(15)) :
                                       cstp_pkg::FuncW'($urandom_range(1023));
  endfunction

  task automatic test_directed();
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_ENTRY, 10'd0, '0);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd3, 32'd7);   // exit on empty stack
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_PROF_START, 10'd3, 32'd7);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_RESERVED, 10'd1023, '1);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd1023, '1);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd0, '0);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd0, 32'd5);  // recursion
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd0, 32'd3);
    // not on top, depth already zero
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd7, 32'd9);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd1023, '1);
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_EXIT, 10'd1023, '1);
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_ENTRY, 10'd0, '0);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'h2aa, 32'h5555_5555);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'h155, 32'haaaa_aaaa);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'h2aa, 32'd1);  // pops the other one
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'h155, 32'd2);
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_RESERVED, 10'h155, '0);
  endtask

  task automatic test_function_count();
    set_function_count(11'd1);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd1, 32'd4);  // unknown
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd0, 32'd4);
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_ENTRY, 10'd1023, '0);
    set_function_count(11'd0);
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_ENTRY, 10'd0, '0);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd0, 32'd4);
    set_function_count(11'd2047);
    send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd0, 32'd4);
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_ENTRY, 10'd1023, '0);
  endtask

  // fill and overflow the stack twice; the second fill saturates one recursion depth
  task automatic test_stack_limits();
    set_function_count(11'd1024);
    repeat (2) begin
      while (sp < NStack) begin
        send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd5, rand_delta());
      end
      send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, 10'd6, 32'd1);
      while (sp > 0) begin
        send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd6, rand_delta());
      end
      send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, 10'd5, 32'd1);
    end
    send_item(cstp_pkg::OP_READ, cstp_pkg::EV_ENTRY, 10'd5, '0);
  endtask

  task automatic test_backpressure();
    drain();
    hold_len = 300;
    repeat (20) send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, rand_func(), rand_delta());
    drain();
    repeat (20) send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT, rand_func(), rand_delta());
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50 && sp < NStack - 16) begin
        send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_ENTRY, rand_func(), rand_delta());
      end else if (r < 85 && sp > 0) begin
        send_item(cstp_pkg::OP_RECORD, cstp_pkg::EV_EXIT,
                  ($urandom_range(9) == 0) ? rand_func() : frames[sp-1], rand_delta());
      end else if (r < 92) begin
        send_item(cstp_pkg::OP_READ, 2'($urandom), rand_func(), $urandom);
      end else if (r < 96) begin
        send_item(cstp_pkg::OP_RECORD,
                  ($urandom_range(1)) ? cstp_pkg::EV_PROF_START : cstp_pkg::EV_RESERVED,
                  rand_func(), $urandom);
      end else begin
        send_item(1'($urandom), 2'($urandom), 10'($urandom), $urandom);
      end
      if (i % 100 == 99) rx_eager = ~rx_eager;
    end
  endtask

  // result side: random stalls and one long hold-off on request
  initial begin
    int s;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_if.ready <= 1'b1;
      end else begin
        s = rx_eager ? 0 : gap_len();
        if (s > 0) begin
          out_if.ready <= 1'b0;
          repeat (s) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    counters_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_counters.size() == 0) begin
        $display("%0t unexpected result: status %0d", $time, out_if.status);
        errors++;
      end else begin
        e = pending_counters.pop_front();
        if (out_if.status !== e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, out_if.status);
          errors++;
        end
        if (out_if.call_count !== e.calls) begin
          $display("%0t call_count: expected %0d actual %0d", $time, e.calls,
                   out_if.call_count);
          errors++;
        end
        if (out_if.inclusive_time !== e.incl) begin
          $display("%0t inclusive_time: expected %0h actual %0h", $time, e.incl,
                   out_if.inclusive_time);
          errors++;
        end
        if (out_if.exclusive_time !== e.excl) begin
          $display("%0t exclusive_time: expected %0h actual %0h", $time, e.excl,
                   out_if.exclusive_time);
          errors++;
        end
        if (out_if.recursion_depth !== e.depth) begin
          $display("%0t recursion_depth: expected %0d actual %0d", $time, e.depth,
                   out_if.recursion_depth);
          errors++;
        end
        if (out_if.path_depth !== e.path) begin
          $display("%0t path_depth: expected %0d actual %0d", $time, e.path,
                   out_if.path_depth);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    hold_len = 0;
    rx_eager = 1'b0;
    known_funcs = cstp_pkg::CfgW'(NFunc);
    now_ticks = '0;
    prev_kind = cstp_pkg::EV_PROF_START;
    sp = 0;
    for (int i = 0; i < NFunc; i++) begin
      calls_of[i] = '0;
      depth_of[i] = '0;
      has_child[i] = 1'b0;
      started_at[i] = '0;
      incl_of[i] = '0;
      excl_of[i] = '0;
    end
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.op = 1'b0;
    in_if.event_kind = '0;
    in_if.func_index = '0;
    in_if.delta_ticks = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_function_count();
    test_stack_limits();
    test_backpressure();
    test_random(300);
    set_function_count(11'd600);
    test_random(200);
    set_function_count(11'd1024);
    test_random(200);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("call_stack_time_profiler_core_tb: clean");
    end else begin
      $display("call_stack_time_profiler_core_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/cstp_pkg.sv
src/cstp_if.sv
src/cstp_ram.sv
src/call_stack_time_profiler_core.sv
tb/call_stack_time_profiler_core_tb.sv
